// File: rtl/dcc_pkg.sv
// Shared types and constants of the DCC packet framer.
`timescale 1ns / 1ps

package dcc_pkg;

    // Payload limits and fixed frame layout
    localparam int          MAX_PAYLOAD         = 5;
    localparam int          PAYLOAD_BYTES       = 5;
    localparam int          FRAME_SLOTS         = 6;
    localparam int          LEN_W               = 3;
    localparam int          IDLE_LENGTH         = 3;
    localparam logic [7:0]  PREAMBLE_RESET      = 8'd16;
    localparam logic [7:0]  IDLE_BYTE_ZERO      = 8'hFF;
    localparam logic [7:0]  IDLE_BYTE_ONE       = 8'h00;
    localparam logic [7:0]  IDLE_BYTE_TWO       = 8'hFF;
    localparam int          DEFAULT_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        has_command;
        logic [63:0] prebuilt_word;
        logic [2:0]  payload_length;
        logic [7:0]  byte_zero;
        logic [7:0]  byte_one;
        logic [7:0]  byte_two;
        logic [7:0]  byte_three;
        logic [7:0]  byte_four;
    } slot_t;

    typedef struct packed {
        logic [31:0] frame_word;
        logic        last_word;
        logic        idle_sent;
    } out_word_t;

    // One classified frame waiting in the queue
    typedef struct packed {
        logic [63:0] frame;
        logic        two_words;
        logic        idle;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: rtl/dcc_stream_if.sv
// Valid/ready channel carrying one payload word per handshake.
`timescale 1ns / 1ps

interface dcc_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

// File: rtl/dcc_front.sv
// Front stage: accepts slot words, builds the 64-bit frame, holds the preamble register.
`timescale 1ns / 1ps

module dcc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            slot_valid,
    output logic            slot_ready,
    input  dcc_pkg::slot_t  slot_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_data,
    output logic            push_valid,
    output dcc_pkg::entry_t push_data,
    input  dcc_pkg::q_stat_t q_stat
);
    import dcc_pkg::*;

    logic [7:0]       preamble_reg;
    logic             vld_reg;
    logic             vld_next;
    entry_t           entry_reg;
    entry_t           entry_next;

    logic [LEN_W-1:0] len_sat;
    logic [LEN_W-1:0] len_eff;
    logic [7:0]       src_byte [FRAME_SLOTS];
    logic [7:0]       slot_byte [FRAME_SLOTS];
    logic [7:0]       checksum;
    logic [63:0]      built;
    logic             take;

    assign cfg_ready  = 1'b1;
    assign slot_ready = !vld_reg || !q_stat.full;
    assign take       = slot_valid && slot_ready;
    assign push_valid = vld_reg;
    assign push_data  = entry_reg;

    // Saturate the length; an idle slot always uses the fixed length
    always_comb
    begin
        if (slot_data.payload_length > LEN_W'(MAX_PAYLOAD))
            len_sat = LEN_W'(MAX_PAYLOAD);
        else
            len_sat = slot_data.payload_length;
        len_eff = slot_data.has_command ? len_sat : LEN_W'(IDLE_LENGTH);
    end

    always_comb
    begin
        if (slot_data.has_command)
        begin
            src_byte[0] = slot_data.byte_zero;
            src_byte[1] = slot_data.byte_one;
            src_byte[2] = slot_data.byte_two;
            src_byte[3] = slot_data.byte_three;
            src_byte[4] = slot_data.byte_four;
        end
        else
        begin
            src_byte[0] = IDLE_BYTE_ZERO;
            src_byte[1] = IDLE_BYTE_ONE;
            src_byte[2] = IDLE_BYTE_TWO;
            src_byte[3] = 8'h00;
            src_byte[4] = 8'h00;
        end
        src_byte[FRAME_SLOTS-1] = 8'h00;
    end

    // Place payload bytes, then the checksum in the slot right after them
    always_comb
    begin
        checksum = 8'h00;
        for (int k = 0; k < PAYLOAD_BYTES; k++)
        begin
            if (LEN_W'(k) < len_eff)
                checksum = checksum ^ src_byte[k];
        end
        built = '0;
        built[63:56] = preamble_reg;
        built[55:48] = {{(8-LEN_W){1'b0}}, len_eff} + 8'd1;
        for (int k = 0; k < FRAME_SLOTS; k++)
        begin
            if (LEN_W'(k) < len_eff)
                slot_byte[k] = src_byte[k];
            else if (LEN_W'(k) == len_eff)
                slot_byte[k] = checksum;
            else
                slot_byte[k] = 8'h00;
            built[(FRAME_SLOTS-1-k)*8 +: 8] = slot_byte[k];
        end
    end

    always_comb
    begin
        vld_next   = vld_reg && q_stat.full;
        entry_next = entry_reg;
        if (take)
        begin
            vld_next = 1'b1;
            if (slot_data.has_command && (slot_data.prebuilt_word != 64'd0))
                entry_next.frame = slot_data.prebuilt_word;
            else
                entry_next.frame = built;
            entry_next.two_words = len_eff > LEN_W'(1);
            entry_next.idle      = !slot_data.has_command;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= 1'b0;
            preamble_reg <= PREAMBLE_RESET;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cfg_valid)
                preamble_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: rtl/dcc_queue.sv
// Short FIFO of classified frames between front and back stages.
`timescale 1ns / 1ps

module dcc_queue #(
    parameter int DEPTH = dcc_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  dcc_pkg::entry_t  push_data,
    input  logic             pop,
    output dcc_pkg::entry_t  head,
    output dcc_pkg::q_stat_t q_stat
);
    import dcc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign q_stat.full  = count_reg == CNT_W'(DEPTH);
    assign q_stat.empty = count_reg == '0;
    assign do_push      = push_valid && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/dcc_back.sv
// Back stage: splits each frame into one or two 32-bit words behind an output register.
`timescale 1ns / 1ps

module dcc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  dcc_pkg::entry_t    head,
    input  dcc_pkg::q_stat_t   q_stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output dcc_pkg::out_word_t out_data
);
    import dcc_pkg::*;

    typedef enum logic {
        ST_UPPER,
        ST_LOWER
    } st_t;

    st_t         state_reg;
    st_t         state_next;
    logic [31:0] lower_reg;
    logic [31:0] lower_next;
    logic        idle_reg;
    logic        idle_next;
    logic        out_vld_reg;
    logic        out_vld_next;
    out_word_t   out_data_reg;
    out_word_t   out_data_next;
    logic        load;

    assign load      = !out_vld_reg || out_ready;
    assign pop       = load && (state_reg == ST_UPPER) && !q_stat.empty;
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next    = state_reg;
        lower_next    = lower_reg;
        idle_next     = idle_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (load)
        begin
            unique case (state_reg)
                ST_LOWER:
                begin
                    out_vld_next             = 1'b1;
                    out_data_next.frame_word = lower_reg;
                    out_data_next.last_word  = 1'b1;
                    out_data_next.idle_sent  = idle_reg;
                    state_next               = ST_UPPER;
                end
                ST_UPPER:
                begin
                    out_vld_next = !q_stat.empty;
                    if (!q_stat.empty)
                    begin
                        out_data_next.frame_word = head.frame[63:32];
                        out_data_next.last_word  = !head.two_words;
                        out_data_next.idle_sent  = head.idle;
                        lower_next               = head.frame[31:0];
                        idle_next                = head.idle;
                        state_next               = head.two_words ? ST_LOWER : ST_UPPER;
                    end
                end
                default:
                begin
                    state_next = ST_UPPER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_UPPER;
            lower_reg    <= '0;
            idle_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            lower_reg    <= lower_next;
            idle_reg     <= idle_next;
            out_vld_reg  <= out_vld_next;
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: rtl/dcc_packet_framer_unit.sv
// Top level of the DCC packet framer: front stage, frame queue and word emitter.
`timescale 1ns / 1ps

// Usage
//   slot  : sink channel, one slot word per handshake (command bytes, prebuilt
//           frame, or an empty slot that becomes the idle packet FF 00 FF).
//   frame : source channel, 32-bit frame words, upper half first; last_word
//           marks the final word of a frame, idle_sent marks idle frames.
//   cfg   : sink channel carrying the 8-bit preamble count; always ready.
//           Write it only while no slot is in flight.
// Path: an accepted slot passes the front register, the queue and the output
//   register; the lower word, when sent, follows in the cycle after the upper
//   is taken. Throughput: the output register emits one word per cycle while
//   frame.ready is high. Slots are accepted back to back into the front
//   register and queue while words drain.
// Reset: preamble count returns to 16, the queue and all stages empty.
// Stall: a held frame word stays stable; the queue fills behind it and
//   slot.ready drops once the front register and queue are both full.
module dcc_packet_framer_unit #(
    parameter int QUEUE_DEPTH = dcc_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    dcc_stream_if.sink   slot,
    dcc_stream_if.source frame,
    dcc_stream_if.sink   cfg
);
    import dcc_pkg::*;

    // Front to queue
    logic    push_valid;
    entry_t  push_data;
    // Queue to back
    entry_t  q_head;
    q_stat_t q_stat;
    logic    q_pop;

    // Accept and classify slots, build the 64-bit frame
    dcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_valid (slot.valid),
        .slot_ready (slot.ready),
        .slot_data  (slot.data),
        .cfg_valid  (cfg.valid),
        .cfg_ready  (cfg.ready),
        .cfg_data   (cfg.data),
        .push_valid (push_valid),
        .push_data  (push_data),
        .q_stat     (q_stat)
    );

    // Decouple building from word emission
    dcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (q_pop),
        .head       (q_head),
        .q_stat     (q_stat)
    );

    // Split each frame into upper and optional lower word
    dcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .out_data  (frame.data)
    );

    // A taken upper word of a two-word frame is followed at once by its lower word
    a_lower_follows : assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame.ready && !frame.data.last_word
        |=> frame.valid && frame.data.last_word)
        else $error("lower word did not follow upper word");

    // Both words of one frame agree on the idle flag
    a_idle_pair : assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame.ready && !frame.data.last_word
        |=> frame.data.idle_sent == $past(frame.data.idle_sent))
        else $error("idle flag changed within a frame");

    // The back stage never pops an empty queue
    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // An accepted slot is held in the front register on the next cycle
    a_slot_held : assert property (@(posedge clk) disable iff (!rst_n)
        slot.valid && slot.ready |=> push_valid)
        else $error("accepted slot lost in front stage");

endmodule

// File: sim/testbench.sv
// Self-checking bench for the DCC packet framer: slot stimulus, frame word checks, preamble writes.
`timescale 1ns / 1ps

module testbench;

    import dcc_pkg::*;

    typedef logic [7:0] preamble_t;

    // Cycles without any handshake before the run is declared hung
    localparam int QUIET_LIMIT  = 3000;
    // Settle time after the last frame word
    localparam int DRAIN_CYCLES = 6;
    // Length of the long receiver hold-off that backs the block up
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 300;
    localparam int PHASES       = 6;
    localparam int IDLE_PCT     = 9;

    // Predicts the frame words of each accepted slot and checks them in order
    class frame_scoreboard;
        preamble_t preamble;
        out_word_t frame_words_due[$];
        int        errors;
        int        words_checked;

        function new();
            preamble      = PREAMBLE_RESET;
            errors        = 0;
            words_checked = 0;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 50)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Lay out count bytes, payload bytes and the XOR checksum
        function logic [63:0] assemble(input int unsigned len,
                                       input logic [7:0] b [PAYLOAD_BYTES]);
            logic [63:0] f;
            logic [7:0]  sum;
            f        = '0;
            sum      = '0;
            f[63:56] = preamble;
            f[55:48] = 8'(len + 1);
            for (int i = 0; i < len; i++)
            begin
                f[(FRAME_SLOTS - 1 - i) * 8 +: 8] = b[i];
                sum ^= b[i];
            end
            f[(FRAME_SLOTS - 1 - len) * 8 +: 8] = sum;
            return f;
        endfunction

        function void note_slot(input slot_t s);
            logic [7:0]  b [PAYLOAD_BYTES];
            logic [63:0] f;
            int unsigned len;
            logic        idle;
            out_word_t   w;
            if (!s.has_command)
            begin
                idle = 1'b1;
                len  = IDLE_LENGTH;
                b    = '{IDLE_BYTE_ZERO, IDLE_BYTE_ONE, IDLE_BYTE_TWO, 8'h00, 8'h00};
                f    = assemble(len, b);
            end
            else
            begin
                idle = 1'b0;
                len  = (s.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : s.payload_length;
                if (s.prebuilt_word != '0)
                    f = s.prebuilt_word;
                else
                begin
                    b = '{s.byte_zero, s.byte_one, s.byte_two, s.byte_three, s.byte_four};
                    f = assemble(len, b);
                end
            end
            w.frame_word = f[63:32];
            w.last_word  = (len <= 1);
            w.idle_sent  = idle;
            frame_words_due.push_back(w);
            if (len > 1)
            begin
                w.frame_word = f[31:0];
                w.last_word  = 1'b1;
                frame_words_due.push_back(w);
            end
        endfunction

        task check_word(input out_word_t got);
            out_word_t want;
            words_checked++;
            if (frame_words_due.size() == 0)
            begin
                report($sformatf("word %h arrived with nothing due", got.frame_word));
                return;
            end
            want = frame_words_due.pop_front();
            if (got.frame_word !== want.frame_word)
                report($sformatf("frame_word got %h want %h", got.frame_word, want.frame_word));
            if (got.last_word !== want.last_word)
                report($sformatf("last_word got %b want %b on %h",
                                 got.last_word, want.last_word, want.frame_word));
            if (got.idle_sent !== want.idle_sent)
                report($sformatf("idle_sent got %b want %b on %h",
                                 got.idle_sent, want.idle_sent, want.frame_word));
        endtask
    endclass

    logic clk;
    logic rst_n;

    dcc_stream_if #(.payload_t(slot_t))     slot_ch ();
    dcc_stream_if #(.payload_t(out_word_t)) frame_ch ();
    dcc_stream_if #(.payload_t(preamble_t)) cfg_ch ();

    frame_scoreboard sb;

    // Knobs shared by the sequence and the receiver process, and run counters
    bit steady;
    int hold_left;
    int slots_sent;
    int settings_used;
    int quiet;

    dcc_packet_framer_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .slot  (slot_ch),
        .frame (frame_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive the slot and cfg inputs to a known value from time zero
    initial
    begin
        slot_ch.valid = 1'b0;
        slot_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
    end

    // Receiver: honor a requested hold-off first, else stall at random
    // unless a steady stretch is running
    initial
    begin
        frame_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                frame_ch.ready = 1'b0;
                hold_left--;
            end
            else
                frame_ch.ready = steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check every frame word taken at a rising edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (frame_ch.valid && frame_ch.ready)
                sb.check_word(frame_ch.data);
        end
    end

    // Watchdog: end the run if no channel moves a word for too long
    initial
    begin
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((slot_ch.valid && slot_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without a handshake, %0d words still due",
                 quiet, sb.frame_words_due.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic slot_t make_slot(input logic has, input logic [63:0] pre,
                                        input logic [2:0] len, input logic [7:0] b0,
                                        input logic [7:0] b1, input logic [7:0] b2,
                                        input logic [7:0] b3, input logic [7:0] b4);
        slot_t s;
        s.has_command    = has;
        s.prebuilt_word  = pre;
        s.payload_length = len;
        s.byte_zero      = b0;
        s.byte_one       = b1;
        s.byte_two       = b2;
        s.byte_three     = b3;
        s.byte_four      = b4;
        return s;
    endfunction

    // Mostly built commands of legal length; some idle slots, prebuilt
    // frames and out-of-range lengths mixed in
    function automatic slot_t random_slot();
        slot_t s;
        int    pick;
        s = make_slot(1'b1, '0, 3'($urandom_range(1, MAX_PAYLOAD)),
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            // idle slot: junk in every ignored field
            s.has_command    = 1'b0;
            s.prebuilt_word  = {$urandom, $urandom};
            s.payload_length = 3'($urandom_range(0, 7));
        end
        else if (pick < 35)
        begin
            s.prebuilt_word  = {$urandom, $urandom};
            s.payload_length = 3'($urandom_range(0, 7));
        end
        else if (pick < 43)
            s.payload_length = 3'($urandom_range(0, 7));
        return s;
    endfunction

    // Offer one slot; idle the sender at random first, then hold until taken
    task automatic send_slot(input slot_t s);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            @(negedge clk);
            slot_ch.valid = 1'b0;
        end
        @(negedge clk);
        slot_ch.valid = 1'b1;
        slot_ch.data  = s;
        do
            @(posedge clk);
        while (!slot_ch.ready);
        sb.note_slot(s);
        slots_sent++;
    endtask

    // Drop valid and wait until every due word is out, then settle
    task automatic wait_frames_out();
        @(negedge clk);
        slot_ch.valid = 1'b0;
        while (sb.frame_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_preamble(input preamble_t v);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.preamble = v;
        settings_used++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    initial
    begin
        slot_t     directed[$];
        preamble_t setting;

        sb            = new();
        steady        = 1'b0;
        hold_left     = 0;
        slots_sent    = 0;
        settings_used = 1;

        // Hold reset, release away from the clock edge
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed slots under the reset preamble count
        directed.push_back(make_slot(1'b0, '0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_slot(1'b0, '1, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        directed.push_back(make_slot(1'b1, '0, 3'd0, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
        directed.push_back(make_slot(1'b1, '0, 3'd1, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_slot(1'b1, '0, 3'd1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        directed.push_back(make_slot(1'b1, '0, 3'd2, 8'h3C, 8'hC3, 8'h11, 8'h22, 8'h33));
        directed.push_back(make_slot(1'b1, '0, 3'd3, 8'hFF, 8'h00, 8'hFF, 8'h77, 8'h88));
        directed.push_back(make_slot(1'b1, '0, 3'd4, 8'h80, 8'h40, 8'h20, 8'h10, 8'hEE));
        directed.push_back(make_slot(1'b1, '0, 3'd5, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10));
        directed.push_back(make_slot(1'b1, '0, 3'd6, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h5A));
        directed.push_back(make_slot(1'b1, '0, 3'd7, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A));
        directed.push_back(make_slot(1'b1, '0, 3'd5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_slot(1'b1, '0, 3'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        directed.push_back(make_slot(1'b1, '1, 3'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_slot(1'b1, '1, 3'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        directed.push_back(make_slot(1'b1, 64'd1, 3'd0, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A));
        directed.push_back(make_slot(1'b1, 64'h8000_0000_0000_0000, 3'd7,
                                     8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
        directed.push_back(make_slot(1'b1, 64'h0000_0000_FFFF_FFFF, 3'd2,
                                     8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_slot(1'b0, 64'h0123_4567_89AB_CDEF, 3'd1,
                                     8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00));
        foreach (directed[i])
            send_slot(directed[i]);
        wait_frames_out();

        // Random phases, each under a new preamble count written while idle
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       setting = 8'hFF;
                1:       setting = 8'h00;
                3:       setting = PREAMBLE_RESET;
                default: setting = 8'($urandom);
            endcase
            write_preamble(setting);
            // first phase runs with no idling on either side
            steady = (phase == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // back the block up: receiver holds off while slots keep coming
                if (phase == 1 && n == 100)
                    hold_left = HOLD_CYCLES;
                // pause the sender until everything due has come out
                if (phase == 2 && n == 150)
                    wait_frames_out();
                send_slot(random_slot());
            end
            wait_frames_out();
            steady = 1'b0;
        end

        $display("covered %0d slots under %0d preamble settings, %0d frame words checked",
                 slots_sent, settings_used, sb.words_checked);
        $display("included idle, prebuilt, zero and saturated lengths, and a %0d-cycle stall",
                 HOLD_CYCLES);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dcc_pkg.sv
rtl/dcc_stream_if.sv
rtl/dcc_front.sv
rtl/dcc_queue.sv
rtl/dcc_back.sv
rtl/dcc_packet_framer_unit.sv
sim/testbench.sv
